### src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants for the text console cell writer
// Command codes, control/status bundles and the hex glyph lookup.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int ADDR_W      = 11;
  localparam int VALUE_W     = 16;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int NUM_W       = 32;
  localparam int CMD_W       = 2;
  localparam int DEC_DIGITS  = 10;
  localparam int CNT_W       = 4;
  localparam int PROD_W      = 2 * NUM_W;
  localparam int RECIP_SHIFT = 35;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [CMD_W-1:0]   CMD_PUT     = 2'd0;
  localparam logic [CMD_W-1:0]   CMD_HEX     = 2'd1;
  localparam logic [CMD_W-1:0]   CMD_DEC     = 2'd2;

  localparam logic [CHAR_W-1:0]  NL_CODE     = 8'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_HEX_A  = 8'h37;  // 'A' - 10
  localparam logic [COLOR_W-1:0] COLOR_RST   = 8'd7;
  localparam logic [NUM_W-1:0]   RECIP_TEN   = 32'hCCCC_CCCD;
  localparam logic [CNT_W-1:0]   HEX_CELLS   = 4'd8;
  localparam logic [CNT_W-1:0]   ONE_CELL    = 4'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_CHAR,
    MODE_HEX,
    MODE_DEC
  } mode_t;

  typedef struct packed {
    logic  load;
    mode_t mode;
    logic  newline;
    logic  mul;
    logic  rem;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic q_zero;
    logic last;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (CHAR_ZERO + wide) : (CHAR_HEX_A + wide);
  endfunction

endpackage

### src/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl: sequencing state machine
// Accepts requests, runs the decimal digit loop and paces the cell writes.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tccw_pkg::CMD_W-1:0]     in_command,
  input  logic [tccw_pkg::CHAR_W-1:0]    in_char_code,
  input  tccw_pkg::dp_stat_t             stat,
  output tccw_pkg::dp_cmd_t              cmd
);
  import tccw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mode  = MODE_CHAR;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_PUT: begin
              if (in_char_code == NL_CODE) begin
                cmd.newline = 1'b1;
              end else begin
                cmd.load  = 1'b1;
                cmd.mode  = MODE_CHAR;
                state_nxt = S_EMIT;
              end
            end
            CMD_HEX: begin
              cmd.load  = 1'b1;
              cmd.mode  = MODE_HEX;
              state_nxt = S_EMIT;
            end
            CMD_DEC: begin
              cmd.load  = 1'b1;
              cmd.mode  = MODE_DEC;
              state_nxt = S_MUL;
            end
            default: ;  // unused code: drop
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = stat.q_zero ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### src/tccw_dp.sv
// ----------------------------------------------------------------------------
// tccw_dp: cursor, digit extraction and output register
// Holds the cursor and color, splits numbers into digits, drives the cells.
// ----------------------------------------------------------------------------
module tccw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tccw_pkg::dp_cmd_t              cmd,
  output tccw_pkg::dp_stat_t             stat,
  input  logic [tccw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tccw_pkg::NUM_W-1:0]     in_number,
  input  logic                           cfg_we,
  input  logic [tccw_pkg::COLOR_W-1:0]   cfg_text_color,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tccw_pkg::ADDR_W-1:0]    out_cell_address,
  output logic [tccw_pkg::VALUE_W-1:0]   out_cell_value,
  output logic                           out_last_of_run
);
  import tccw_pkg::*;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SUM_W = COL_W + ROW_W;
  localparam int AW    = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt, row_inc;
  logic [COLOR_W-1:0] color_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   cnt_r;
  mode_t              mode_r;
  logic [CHAR_W-1:0]  char_r;
  logic [NUM_W-1:0]   num_r;
  logic [PROD_W-1:0]  prod_r;
  logic [3:0]         dig_r [DEC_DIGITS];
  logic [ADDR_W-1:0]  addr_r;
  logic [VALUE_W-1:0] value_r;
  logic               last_r;

  logic [QUOT_W-1:0]  quot;
  logic [NUM_W-1:0]   quot_ext;
  logic [NUM_W-1:0]   rem_full;
  logic [CNT_W-1:0]   pop_idx;
  logic [CHAR_W-1:0]  glyph;
  logic [AW-1:0]      addr_full;

  assign quot     = prod_r[PROD_W-1:RECIP_SHIFT];
  assign quot_ext = NUM_W'(quot);
  // remainder = v - 10*q, with 10*q as two shifts
  assign rem_full = num_r - ((quot_ext << 3) + (quot_ext << 1));
  assign pop_idx  = cnt_r - ONE_CELL;

  assign stat.q_zero    = (quot == '0);
  assign stat.last      = (cnt_r == ONE_CELL);
  assign stat.slot_free = !out_valid_r || out_ready;

  assign addr_full = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);

  always_comb begin
    case (mode_r)
      MODE_CHAR: glyph = char_r;
      MODE_HEX:  glyph = hex_glyph(num_r[NUM_W-1 -: 4]);
      MODE_DEC:  glyph = CHAR_ZERO + {4'h0, dig_r[pop_idx]};
      default:   glyph = char_r;
    endcase
  end

  // cursor: next row wraps, column wraps into the next row
  always_comb begin
    row_inc = (row_r == ROW_W'(ROWS - 1)) ? '0 : row_r + 1'b1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.newline) begin
      col_nxt = '0;
      row_nxt = row_inc;
    end else if (cmd.emit) begin
      if (col_r == COL_W'(COLUMNS - 1)) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      color_r     <= COLOR_RST;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= MODE_CHAR;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        color_r <= cfg_text_color;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        mode_r <= cmd.mode;
        case (cmd.mode)
          MODE_CHAR: cnt_r <= ONE_CELL;
          MODE_HEX:  cnt_r <= HEX_CELLS;
          default:   cnt_r <= '0;
        endcase
      end else if (cmd.rem) begin
        cnt_r <= cnt_r + ONE_CELL;
      end else if (cmd.emit) begin
        cnt_r <= pop_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_code;
      num_r  <= in_number;
    end else if (cmd.rem) begin
      num_r <= quot_ext;
    end else if (cmd.emit && mode_r == MODE_HEX) begin
      num_r <= num_r << 4;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(num_r) * PROD_W'(RECIP_TEN);
    end
    if (cmd.rem) begin
      dig_r[cnt_r] <= rem_full[3:0];
    end
    if (cmd.emit) begin
      addr_r  <= addr_full[ADDR_W-1:0];
      value_r <= {color_r, glyph};
      last_r  <= stat.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_address = addr_r;
  assign out_cell_value   = value_r;
  assign out_last_of_run  = last_r;

endmodule

### src/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer: text-mode console cell writer
// Turns character, hex and decimal requests into screen cell writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake. in_command selects put character (0),
//           eight hex digits (1) or decimal (2); code 3 is dropped. A newline
//           byte moves the cursor to column 0 of the next row and writes no cell.
//   out_* : one cell write per handshake, address row*COLUMNS+column and value
//           {color, character}; out_last_of_run flags the final cell of a request.
//   cfg_* : write the attribute byte; take it only while the block is idle.
// Timing:
//   A request is taken on its handshake and its cells follow one per cycle
//   while out_ready is high. Put character and hex go straight to the cell
//   loop; decimal first runs the divide-by-ten loop (reciprocal multiply, then
//   remainder) once per digit, then sends the digits out. The next request is
//   taken once the last cell sits in the output register.
// Reset: cursor to row 0 column 0, color 7, output empty.
// Stall: the output register holds while out_ready is low; the cell loop
//   waits on it and in_ready stays low until the request finishes.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tccw_pkg::CMD_W-1:0]     in_command,
  input  logic [tccw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tccw_pkg::NUM_W-1:0]     in_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tccw_pkg::ADDR_W-1:0]    out_cell_address,
  output logic [tccw_pkg::VALUE_W-1:0]   out_cell_value,
  output logic                           out_last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tccw_pkg::COLOR_W-1:0]   cfg_text_color
);
  import tccw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // attribute register is always ready to take a write
  assign cfg_ready = 1'b1;

  // sequencing: request accept, digit loop, cell pacing
  tccw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .stat         (stat),
    .cmd          (cmd)
  );

  // cursor, digit extraction and output register
  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_char_code     (in_char_code),
    .in_number        (in_number),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_text_color   (cfg_text_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_address (out_cell_address),
    .out_cell_value   (out_cell_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

### bench/tb_text_console_cell_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer: self-checking bench for the console cell writer
// Drives put-character, hex, decimal and unused requests through the request
// channel. A cursor tracker in the bench predicts every cell write, and each
// write is checked field by field. The attribute byte is changed between
// phases. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer;
  import tccw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int QUIET_CYCLES = 40;      // longer than the slowest decimal request
  localparam int CYCLE_LIMIT  = 500000;

  // Code 3 has no meaning in the block; the block drops it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Glyphs for one digit, most significant character first.
  localparam logic [8*16-1:0] GLYPH_TABLE = "0123456789ABCDEF";

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
    logic               last;
  } cell_write_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CHAR_W-1:0]  char_code;
    logic [NUM_W-1:0]   number;
    logic               typed;      // expected cell written by hand below
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
  } opening_row_t;

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command     = '0;
  logic [CHAR_W-1:0]   in_char_code   = '0;
  logic [NUM_W-1:0]    in_number      = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [ADDR_W-1:0]   out_cell_address;
  logic [VALUE_W-1:0]  out_cell_value;
  logic                out_last_of_run;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [COLOR_W-1:0]  cfg_text_color = '0;

  // Cursor tracker state, mirrors what the block should hold.
  logic [4:0]          cursor_row;
  logic [6:0]          cursor_col;
  logic [COLOR_W-1:0]  attr_byte;

  cell_write_t         pending_cells[$];
  opening_row_t        opening_rows[$];

  int error_count    = 0;
  int cells_checked  = 0;
  int requests_done  = 0;
  int newline_count  = 0;
  int ignored_count  = 0;
  int screen_wraps   = 0;
  int colors_written = 0;
  int cycle_count    = 0;
  int burst_left     = 1;
  bit steady_sender  = 1'b0;

  logic [5:0] rx_beat = '0;
  logic [1:0] rx_mode = '0;

  text_console_cell_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_char_code     (in_char_code),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_address (out_cell_address),
    .out_cell_value   (out_cell_value),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_text_color   (cfg_text_color)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d cell writes outstanding",
               $time, pending_cells.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Cursor tracker
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [3:0] nib);
    return GLYPH_TABLE[(15 - int'(nib)) * 8 +: 8];
  endfunction

  // Move to the next row; there is no scrolling, so wrap to the top.
  function automatic void next_line();
    if (int'(cursor_row) + 1 >= ROWS) begin
      cursor_row = '0;
      screen_wraps++;
    end else begin
      cursor_row = cursor_row + 1'b1;
    end
  endfunction

  // Queue one cell write at the cursor, then advance the cursor.
  function automatic void place_cell(input logic [CHAR_W-1:0] glyph);
    cell_write_t c;
    int          linear;
    linear    = int'(cursor_row) * COLUMNS + int'(cursor_col);
    c.address = linear[ADDR_W-1:0];
    c.value   = {attr_byte, glyph};
    c.last    = 1'b0;
    pending_cells.push_back(c);
    if (int'(cursor_col) + 1 >= COLUMNS) begin
      cursor_col = '0;
      next_line();
    end else begin
      cursor_col = cursor_col + 1'b1;
    end
  endfunction

  // Work out every cell write caused by one accepted request.
  function automatic void predict_request(input logic [CMD_W-1:0]  cmd,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [NUM_W-1:0]  num);
    logic [3:0]       digits[10];
    logic [NUM_W-1:0] rest;
    int               n;
    int               i;
    int               queued_before;
    queued_before = pending_cells.size();
    case (cmd)
      CMD_PUT: begin
        if (ch == NL_CODE) begin
          cursor_col = '0;
          next_line();
        end else begin
          place_cell(ch);
        end
      end
      CMD_HEX: begin
        for (i = 7; i >= 0; i--) place_cell(glyph_of(num[i*4 +: 4]));
      end
      CMD_DEC: begin
        // Peel digits off the low end, then emit them high end first.
        rest = num;
        n    = 0;
        do begin
          digits[n] = 4'(rest % 32'd10);
          rest      = rest / 32'd10;
          n++;
        end while (rest != 0);
        for (i = n - 1; i >= 0; i--) place_cell(glyph_of(digits[i]));
      end
      default: ;
    endcase
    if (pending_cells.size() > queued_before)
      pending_cells[pending_cells.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------

  // Pick a new stall pattern each time rx_beat wraps: always ready, coin flip,
  // ready only when the low three bits of rx_beat are zero, or mostly ready.
  always @(posedge clk) begin
    rx_beat <= rx_beat + 1'b1;
    if (rx_beat == '0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_ready <= (rx_beat[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic void flag_field(input string name, input int unsigned want,
                                     input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    error_count++;
  endfunction

  // Compare each accepted cell write with the oldest prediction.
  always @(posedge clk) begin : check_cells
    cell_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: cell write with none expected, expected nothing, got %0h/%0h/%0b",
                 $time, out_cell_address, out_cell_value, out_last_of_run);
        error_count++;
      end else begin
        want = pending_cells.pop_front();
        cells_checked++;
        if (out_cell_address !== want.address)
          flag_field("cell_address", want.address, out_cell_address);
        if (out_cell_value !== want.value)
          flag_field("cell_value", want.value, out_cell_value);
        if (out_last_of_run !== want.last)
          flag_field("last_of_run", want.last, out_last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Hold the request until it is taken, predict it, then maybe idle for a
  // while. Valid stays up across a burst, so back-to-back requests never
  // lower it.
  task automatic send_request(input logic [CMD_W-1:0]  cmd,
                              input logic [CHAR_W-1:0] ch,
                              input logic [NUM_W-1:0]  num);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_char_code <= ch;
    in_number    <= num;
    do @(posedge clk); while (!in_ready);
    predict_request(cmd, ch, num);
    requests_done++;
    if (cmd == CMD_UNUSED) ignored_count++;
    if (cmd == CMD_PUT && ch == NL_CODE) newline_count++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady_sender) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Drop valid, drain every predicted write, then give a trailing newline or
  // dropped request time to finish inside the block.
  task automatic wait_until_quiet();
    if (in_valid) in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] color);
    cfg_valid      <= 1'b1;
    cfg_text_color <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr_byte = color;
    colors_written++;
  endtask

  // Numbers: fully random, small, around powers of ten, or a single bit
  // flipped against all zeros or all ones.
  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] p;
    int               k;
    case ($urandom_range(0, 3))
      0: p = $urandom();
      1: p = $urandom_range(0, 999);
      2: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        if ($urandom_range(0, 1) == 1) p = p - 1;
      end
      default: p = {NUM_W{$urandom_range(0, 1) == 1}} ^ (32'h1 << $urandom_range(0, 31));
    endcase
    return p;
  endfunction

  // Random requests; dropped requests do not count toward the phase.
  task automatic run_random(input int count);
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    int                sent;
    int                pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       cmd = CMD_UNUSED;
      else if (pick < 44) cmd = CMD_PUT;
      else if (pick < 64) cmd = CMD_HEX;
      else                cmd = CMD_DEC;
      ch = ($urandom_range(0, 4) == 0) ? NL_CODE : 8'($urandom_range(0, 255));
      send_request(cmd, ch, pick_number());
      if (cmd != CMD_UNUSED) sent++;
    end
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                         input logic [NUM_W-1:0] num, input logic typed,
                         input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] value);
    opening_row_t r;
    r = '{command: cmd, char_code: ch, number: num, typed: typed,
          address: addr, value: value};
    opening_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    opening_row_t row_now;
    int           k;

    cursor_row = '0;
    cursor_col = '0;
    attr_byte  = COLOR_RST;

    // Directed requests, reset color. Hand-typed cells follow the cursor from
    // the top-left corner.
    add_row(CMD_PUT,    8'h41,   32'h0,          1'b1, 11'd0,   16'h0741);
    add_row(CMD_PUT,    8'h00,   32'h0,          1'b1, 11'd1,   16'h0700);
    add_row(CMD_PUT,    8'hFF,   32'hFFFF_FFFF,  1'b1, 11'd2,   16'h07FF);
    add_row(CMD_PUT,    NL_CODE, 32'h0,          1'b0, '0,      '0);
    add_row(CMD_PUT,    8'h42,   32'h0,          1'b1, 11'd80,  16'h0742);
    add_row(CMD_UNUSED, 8'h5A,   32'hFFFF_FFFF,  1'b0, '0,      '0);
    add_row(CMD_PUT,    8'h0B,   32'h0,          1'b1, 11'd81,  16'h070B);
    add_row(CMD_PUT,    8'h09,   32'h0,          1'b1, 11'd82,  16'h0709);
    add_row(CMD_HEX,    8'h00,   32'h0,          1'b0, '0,      '0);
    add_row(CMD_HEX,    8'hFF,   32'hFFFF_FFFF,  1'b0, '0,      '0);
    add_row(CMD_HEX,    8'h00,   32'h0123_4567,  1'b0, '0,      '0);
    add_row(CMD_HEX,    8'h00,   32'h89AB_CDEF,  1'b0, '0,      '0);
    add_row(CMD_DEC,    8'h00,   32'd0,          1'b1, 11'd115, 16'h0730);
    add_row(CMD_DEC,    8'h00,   32'hFFFF_FFFF,  1'b0, '0,      '0);
    add_row(CMD_DEC,    8'h00,   32'd1000000000, 1'b0, '0,      '0);
    add_row(CMD_DEC,    8'h00,   32'd999999999,  1'b0, '0,      '0);
    add_row(CMD_DEC,    8'h00,   32'd9,          1'b0, '0,      '0);
    add_row(CMD_DEC,    8'h00,   32'd10,         1'b0, '0,      '0);
    add_row(CMD_DEC,    8'h00,   32'd1,          1'b0, '0,      '0);
    add_row(CMD_UNUSED, NL_CODE, 32'h0,          1'b0, '0,      '0);
    add_row(CMD_PUT,    NL_CODE, 32'h0,          1'b0, '0,      '0);
    add_row(CMD_PUT,    NL_CODE, 32'h0,          1'b0, '0,      '0);
    add_row(CMD_PUT,    8'h7F,   32'h0,          1'b0, '0,      '0);
    add_row(CMD_HEX,    8'h00,   32'hA5A5_5A5A,  1'b0, '0,      '0);
    add_row(CMD_DEC,    8'h00,   32'h8000_0000,  1'b0, '0,      '0);

    // Hold reset once at the start, then release it.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table. For hand-typed rows, replace the tracker's
    // single cell with the typed one.
    for (k = 0; k < opening_rows.size(); k++) begin
      row_now = opening_rows[k];
      send_request(row_now.command, row_now.char_code, row_now.number);
      if (row_now.typed)
        pending_cells[pending_cells.size() - 1] =
          '{address: row_now.address, value: row_now.value, last: 1'b1};
    end

    // Random phases, one color each, the extremes first. The first phase
    // keeps the request side busy with no gaps.
    wait_until_quiet();
    write_color(8'hFF);
    steady_sender = 1'b1;
    run_random(60);

    wait_until_quiet();
    write_color(8'h00);
    steady_sender = 1'b0;
    run_random(70);

    wait_until_quiet();
    write_color(8'($urandom_range(1, 254)));
    run_random(70);

    wait_until_quiet();
    write_color(8'h1E);
    run_random(70);

    wait_until_quiet();

    $display("Covered %0d requests (%0d newlines, %0d dropped) and %0d checked cell writes,",
             requests_done, newline_count, ignored_count, cells_checked);
    $display("with %0d color writes and %0d wraps of the cursor to the top row.",
             colors_written, screen_wraps);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
